### sv/ac_ir_frame_pulse_encoder_macros.svh
// assertion macros used by the checker file
`ifndef AC_IR_FRAME_PULSE_ENCODER_MACROS_SVH
`define AC_IR_FRAME_PULSE_ENCODER_MACROS_SVH

// property checked on every clock edge outside reset
`define ACIRFE_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ACIRFE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/acirfe_pkg.sv
// types, constants and frame byte coding for the ir frame pulse encoder
`default_nettype none

package acirfe_pkg;

  localparam int FRAME_LEN  = 14;
  localparam int FRAME_BITS = FRAME_LEN * 8;
  localparam int ADDR_W     = $clog2(FRAME_LEN);
  localparam int PAIR_W     = 7;
  localparam int BIT_W      = 3;
  localparam int TIME_W     = 16;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_LEN - 1);
  localparam logic [PAIR_W-1:0] FIRST_DATA_PAIR = PAIR_W'(1);
  localparam logic [PAIR_W-1:0] LAST_DATA_PAIR  = PAIR_W'(FRAME_BITS);

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  // register indexes on the config port
  typedef enum logic [2:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_GAP          = 3'd5
  } reg_index_t;

  localparam logic [TIME_W-1:0] RST_HEADER_MARK  = 16'd3000;
  localparam logic [TIME_W-1:0] RST_HEADER_SPACE = 16'd1650;
  localparam logic [TIME_W-1:0] RST_BIT_MARK     = 16'd500;
  localparam logic [TIME_W-1:0] RST_ONE_SPACE    = 16'd1050;
  localparam logic [TIME_W-1:0] RST_ZERO_SPACE   = 16'd325;
  localparam logic [TIME_W-1:0] RST_GAP          = 16'd30000;

  // kind of pair in flight
  typedef enum logic [1:0] {
    PAIR_HEADER,
    PAIR_DATA,
    PAIR_FOOTER
  } pair_kind_t;

  // mode input codes
  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_COOL = 3'd1;
  localparam logic [2:0] MODE_DRY  = 3'd2;
  localparam logic [2:0] MODE_FAN  = 3'd3;
  localparam logic [2:0] MODE_HEAT = 3'd4;

  // mode codes on the air
  localparam logic [7:0] MCODE_AUTO = 8'd8;
  localparam logic [7:0] MCODE_COOL = 8'd3;
  localparam logic [7:0] MCODE_DRY  = 8'd2;
  localparam logic [7:0] MCODE_FAN  = 8'd7;
  localparam logic [7:0] MCODE_HEAT = 8'd1;

  // fan codes on the air
  localparam logic [7:0] FCODE_AUTO = 8'd0;
  localparam logic [7:0] FCODE_LOW  = 8'd2;
  localparam logic [7:0] FCODE_MED  = 8'd3;
  localparam logic [7:0] FCODE_HIGH = 8'd5;

  // fixed frame bytes
  localparam logic [7:0] BYTE0      = 8'h23;
  localparam logic [7:0] BYTE1      = 8'hCB;
  localparam logic [7:0] BYTE2      = 8'h26;
  localparam logic [7:0] BYTE3      = 8'h01;
  localparam logic [7:0] BYTE5_BASE = 8'h20;
  localparam logic [7:0] POWER_BIT  = 8'h04;
  localparam logic [7:0] BYTE8_BASE = 8'h40;
  localparam logic [7:0] SWING_BITS = 8'h38;
  localparam logic [7:0] TEMP_MIN   = 8'd16;
  localparam logic [7:0] TEMP_MAX   = 8'd31;
  localparam logic [7:0] NIBBLE     = 8'h0F;
  localparam logic [7:0] CSUM_BASE  = 8'((BYTE0 + BYTE1 + BYTE2 + BYTE3) & 9'h0FF);

  // frame byte addresses
  localparam logic [ADDR_W-1:0] ADDR_B0    = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_B1    = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_B2    = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] ADDR_B3    = ADDR_W'(3);
  localparam logic [ADDR_W-1:0] ADDR_POWER = ADDR_W'(5);
  localparam logic [ADDR_W-1:0] ADDR_MODE  = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] ADDR_TEMP  = ADDR_W'(7);
  localparam logic [ADDR_W-1:0] ADDR_FAN   = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] ADDR_CSUM  = ADDR_W'(FRAME_LEN - 1);

  // settings captured on a load
  typedef struct packed {
    logic       power_on;
    logic [2:0] ac_mode;
    logic [1:0] fan_speed;
    logic       swing_on;
    logic [7:0] temperature_c;
  } settings_t;

  // read request into the frame store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  function automatic logic [7:0] mode_code(input logic [2:0] mode);
    logic [7:0] code;
    case (mode)
      MODE_COOL: code = MCODE_COOL;
      MODE_DRY:  code = MCODE_DRY;
      MODE_FAN:  code = MCODE_FAN;
      MODE_HEAT: code = MCODE_HEAT;
      default:   code = MCODE_AUTO;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] fan_byte(input settings_t s);
    logic [7:0] fan;
    case (s.fan_speed)
      2'd1:    fan = FCODE_LOW;
      2'd2:    fan = FCODE_MED;
      2'd3:    fan = FCODE_HIGH;
      default: fan = FCODE_AUTO;
    endcase
    // fan-only mode always runs the fan high
    if (mode_code(s.ac_mode) == MCODE_FAN) fan = FCODE_HIGH;
    return BYTE8_BASE | fan | (s.swing_on ? SWING_BITS : 8'h00);
  endfunction

  function automatic logic [7:0] temp_byte(input logic [7:0] temp);
    logic [7:0] t;
    t = temp;
    if (t < TEMP_MIN) t = TEMP_MIN;
    if (t > TEMP_MAX) t = TEMP_MAX;
    return (TEMP_MAX - t) & NIBBLE;
  endfunction

  function automatic logic [7:0] power_byte(input settings_t s);
    return BYTE5_BASE | (s.power_on ? POWER_BIT : 8'h00);
  endfunction

  // one byte of the frame for a given address
  function automatic logic [7:0] frame_byte(input logic [ADDR_W-1:0] addr,
                                            input settings_t s);
    logic [7:0] b;
    case (addr)
      ADDR_B0:    b = BYTE0;
      ADDR_B1:    b = BYTE1;
      ADDR_B2:    b = BYTE2;
      ADDR_B3:    b = BYTE3;
      ADDR_POWER: b = power_byte(s);
      ADDR_MODE:  b = mode_code(s.ac_mode) & NIBBLE;
      ADDR_TEMP:  b = temp_byte(s.temperature_c);
      ADDR_FAN:   b = fan_byte(s);
      ADDR_CSUM:  b = CSUM_BASE + power_byte(s) + (mode_code(s.ac_mode) & NIBBLE)
                      + temp_byte(s.temperature_c) + fan_byte(s);
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### sv/ac_ir_frame_pulse_encoder.sv
// top level of the ir air-conditioner frame pulse encoder
`default_nettype none

// Takes one word per cycle while in_stall is low and returns at most one
// mark/space pair per word, via the frame store read and output register.
// A load word (command 0) captures the settings and returns the header pair;
// each next word (command 1) returns the next pair: 112 data bits LSB-first
// from byte 0, then the footer pair with last_pair set. A next word while no
// frame is in progress returns nothing. The 14-byte frame lives in a
// one-read one-write memory; after a load it is written one byte per cycle,
// which always stays ahead of the bit reads. Timing registers should be
// written through the cfg port only while the block is idle; the block does
// not enforce this. cfg_ready is always high.

module ac_ir_frame_pulse_encoder
  import acirfe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // input words
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              command,
  input  wire logic              power_on,
  input  wire logic [2:0]        ac_mode,
  input  wire logic [1:0]        fan_speed,
  input  wire logic              swing_on,
  input  wire logic [7:0]        temperature_c,
  // output words
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [TIME_W-1:0]      mark_us,
  output logic [TIME_W-1:0]      space_us,
  output logic                   last_pair,
  // config writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [TIME_W-1:0] cfg_data
);

  logic [TIME_W-1:0] header_mark_us;
  logic [TIME_W-1:0] header_space_us;
  logic [TIME_W-1:0] bit_mark_us;
  logic [TIME_W-1:0] one_space_us;
  logic [TIME_W-1:0] zero_space_us;
  logic [TIME_W-1:0] gap_us;

  logic [PAIR_W-1:0] pair_index;
  logic              sending;
  logic              accept;
  logic              is_load;
  logic              is_data;
  logic [PAIR_W-1:0] bit_k;

  logic              s1_valid;
  pair_kind_t        s1_kind;
  logic [BIT_W-1:0]  s1_bit;
  logic              s1_adv;

  settings_t         settings;
  rd_req_t           rd;
  logic [7:0]        rd_data;

  logic [TIME_W-1:0] mark_next;
  logic [TIME_W-1:0] space_next;
  logic              last_next;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_us  <= RST_HEADER_MARK;
      header_space_us <= RST_HEADER_SPACE;
      bit_mark_us     <= RST_BIT_MARK;
      one_space_us    <= RST_ONE_SPACE;
      zero_space_us   <= RST_ZERO_SPACE;
      gap_us          <= RST_GAP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_MARK:  header_mark_us  <= cfg_data;
        REG_HEADER_SPACE: header_space_us <= cfg_data;
        REG_BIT_MARK:     bit_mark_us     <= cfg_data;
        REG_ONE_SPACE:    one_space_us    <= cfg_data;
        REG_ZERO_SPACE:   zero_space_us   <= cfg_data;
        REG_GAP:          gap_us          <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and word decode
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_load  = (command == CMD_LOAD);
  assign is_data  = (pair_index >= FIRST_DATA_PAIR) && (pair_index <= LAST_DATA_PAIR);
  assign bit_k    = pair_index - 1'b1;

  assign settings = '{power_on:      power_on,
                      ac_mode:       ac_mode,
                      fan_speed:     fan_speed,
                      swing_on:      swing_on,
                      temperature_c: temperature_c};

  assign rd.en   = accept && !is_load && sending && is_data;
  assign rd.addr = ADDR_W'(bit_k >> BIT_W);

  acirfe_frame_store u_store (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && is_load),
    .settings (settings),
    .rd       (rd),
    .rd_data  (rd_data)
  );

  // frame progress and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_index <= '0;
      sending    <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (is_load) begin
          pair_index <= FIRST_DATA_PAIR;
          sending    <= 1'b1;
        end else if (sending) begin
          if (is_data) begin
            pair_index <= pair_index + 1'b1;
          end else begin
            pair_index <= '0;
            sending    <= 1'b0;
          end
        end
      end

      if (accept) begin
        s1_valid <= is_load || sending;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_load) begin
        s1_kind <= PAIR_HEADER;
      end else if (is_data) begin
        s1_kind <= PAIR_DATA;
      end else begin
        s1_kind <= PAIR_FOOTER;
      end
      s1_bit <= bit_k[BIT_W-1:0];
    end
  end

  // pair timing select
  always_comb begin
    mark_next  = bit_mark_us;
    space_next = gap_us;
    last_next  = 1'b0;
    case (s1_kind)
      PAIR_HEADER: begin
        mark_next  = header_mark_us;
        space_next = header_space_us;
      end
      PAIR_DATA: begin
        space_next = rd_data[s1_bit] ? one_space_us : zero_space_us;
      end
      PAIR_FOOTER: begin
        last_next = 1'b1;
      end
      default: begin
        last_next = 1'b1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      mark_us   <= mark_next;
      space_us  <= space_next;
      last_pair <= last_next;
    end
  end

endmodule

`default_nettype wire

### sv/acirfe_frame_store.sv
// frame byte memory with a write sweep after each load and read forwarding
`default_nettype none

module acirfe_frame_store
  import acirfe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire settings_t settings,
  input  wire rd_req_t   rd,
  output logic [7:0]     rd_data
);

  logic [7:0]        mem [FRAME_LEN];
  settings_t         set_r;
  logic              sweep_on;
  logic [ADDR_W-1:0] wr_idx;
  logic [7:0]        wr_data;

  // settings held for the sweep
  always_ff @(posedge clk) begin
    if (load) begin
      set_r <= settings;
    end
  end

  // sweep counter, one byte per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_on <= 1'b0;
      wr_idx   <= '0;
    end else if (load) begin
      sweep_on <= 1'b1;
      wr_idx   <= '0;
    end else if (sweep_on) begin
      if (wr_idx == LAST_ADDR) begin
        sweep_on <= 1'b0;
      end else begin
        wr_idx <= wr_idx + 1'b1;
      end
    end
  end

  assign wr_data = frame_byte(wr_idx, set_r);

  // write port
  always_ff @(posedge clk) begin
    if (sweep_on) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // read port, forwarding a byte written on the same edge
  always_ff @(posedge clk) begin
    if (rd.en) begin
      if (sweep_on && (wr_idx == rd.addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd.addr];
      end
    end
  end

endmodule

`default_nettype wire

### sv/acirfe_checker.sv
// port-level checker for the ir frame pulse encoder, bound to the top level
`default_nettype none

`include "ac_ir_frame_pulse_encoder_macros.svh"

module acirfe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        command,
  input wire logic        power_on,
  input wire logic [2:0]  ac_mode,
  input wire logic [1:0]  fan_speed,
  input wire logic        swing_on,
  input wire logic [7:0]  temperature_c,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] mark_us,
  input wire logic [15:0] space_us,
  input wire logic        last_pair,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [2:0]  cfg_index,
  input wire logic [15:0] cfg_data
);

  // a stalled word stays offered
  `ACIRFE_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "output word dropped while stalled")

  // a stalled word keeps its payload
  `ACIRFE_ASSERT_RST(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(mark_us) && $stable(space_us) && $stable(last_pair), "output payload changed while stalled")

  // reset empties the pipeline
  `ACIRFE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !in_stall, "pipeline not empty after reset")

  // input only backs up behind a waiting output word
  `ACIRFE_ASSERT_RST(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall, "input stalled without a stalled output word")

endmodule

bind ac_ir_frame_pulse_encoder acirfe_checker u_acirfe_checker (.*);

`default_nettype wire
